// ===== design/obst_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the order book snapshot table.
// No dependencies.
package obst_pkg;

  localparam int SYMBOLS           = 8;
  localparam int ORDERS_PER_SYMBOL = 1024;
  localparam int SYM_W             = 3;
  localparam int OID_W             = 10;
  localparam int ADDR_W            = SYM_W + OID_W;
  localparam int SLOTS             = SYMBOLS * ORDERS_PER_SYMBOL;
  localparam int SEQ_W             = 32;
  localparam int DATA_W            = 32;
  localparam int SIDE_W            = 2;
  localparam int IDX_W             = 16;
  localparam int MSG_N             = 5;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_SCAN   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    UPD_ADD    = 2'd0,
    UPD_MODIFY = 2'd1,
    UPD_CANCEL = 2'd2,
    UPD_OTHER  = 2'd3
  } upd_e;

  typedef enum logic [2:0] {
    MSG_ACK   = 3'd0,
    MSG_START = 3'd1,
    MSG_CLEAR = 3'd2,
    MSG_ORDER = 3'd3,
    MSG_END   = 3'd4
  } msg_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_DUP     = 3'd1,
    STAT_MISSING = 3'd2,
    STAT_SIDE    = 3'd3,
    STAT_BUSY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [SIDE_W-1:0] side;
    logic [DATA_W-1:0] price;
    logic [DATA_W-1:0] qty;
    logic [DATA_W-1:0] prio;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== design/obst_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module obst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/order_book_snapshot_table.sv =====
`timescale 1ns / 1ps
// Order book snapshot table: top level, state machine and output register.
// Depends on obst_pkg and obst_ram.
// Order: the input transaction and the slot read are registered on acceptance, S_EXEC
// evaluates them, and S_EMIT loads the first result into the output register, later
// while an earlier result is still held there.
// Throughput: one item at a time, set by the read-modify-write of the slot memory and
// the one-result-per-cycle output register, which a low out_ready_i stalls.
// Reset: after rst_ni rises, a clearing pass zeroes all 8192 slots with in_ready_o low.
module order_book_snapshot_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [1:0]                    update_type_i,
  input  logic [obst_pkg::SEQ_W-1:0]    seq_num_i,
  input  logic [obst_pkg::SYM_W-1:0]    symbol_i,
  input  logic [obst_pkg::OID_W-1:0]    order_id_i,
  input  logic [obst_pkg::SIDE_W-1:0]   side_i,
  input  logic signed [obst_pkg::DATA_W-1:0] price_i,
  input  logic [obst_pkg::DATA_W-1:0]   quantity_i,
  input  logic [obst_pkg::DATA_W-1:0]   priority_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    msg_kind_o,
  output logic [obst_pkg::IDX_W-1:0]    snap_index_o,
  output logic [obst_pkg::SYM_W-1:0]    out_symbol_o,
  output logic [obst_pkg::DATA_W-1:0]   ref_value_o,
  output logic [obst_pkg::SIDE_W-1:0]   out_side_o,
  output logic signed [obst_pkg::DATA_W-1:0] out_price_o,
  output logic [obst_pkg::DATA_W-1:0]   out_quantity_o,
  output logic [obst_pkg::DATA_W-1:0]   out_priority_o,
  output logic [2:0]                    status_o,
  output logic                          seq_error_o,
  output logic                          last_o
);
  import obst_pkg::*;

  state_e state_q, state_d;

  op_e               op_q;
  upd_e              kind_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [SYM_W-1:0]  sym_q;
  logic [OID_W-1:0]  oid_q;
  logic [SIDE_W-1:0] side_q;
  logic [DATA_W-1:0] price_q, qty_q, prio_q;
  logic [ADDR_W-1:0] addr_q;
  slot_t             slot_q, slot_d;
  status_e           res_status_q, res_status_d;
  logic              res_seqerr_q, res_seqerr_d;

  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] cursor_q, cursor_d;
  logic [SEQ_W-1:0]  last_seq_q, last_seq_d;
  logic [IDX_W-1:0]  snap_cnt_q, snap_cnt_d;
  logic [MSG_N-1:0]  pend_q, pend_d;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  msg_e              o_kind_q, o_kind_d;
  logic [IDX_W-1:0]  o_idx_q, o_idx_d;
  logic [SYM_W-1:0]  o_sym_q, o_sym_d;
  logic [DATA_W-1:0] o_ref_q, o_ref_d;
  logic [SIDE_W-1:0] o_side_q, o_side_d;
  logic [DATA_W-1:0] o_price_q, o_price_d;
  logic [DATA_W-1:0] o_qty_q, o_qty_d;
  logic [DATA_W-1:0] o_prio_q, o_prio_d;
  status_e           o_status_q, o_status_d;
  logic              o_seqerr_q, o_seqerr_d;
  logic              o_last_q, o_last_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  slot_t             ram_wdata, ram_rdata;
  logic              in_acc;
  msg_e              sel_kind;
  logic              in_range;

  obst_ram #(
    .Width (SLOT_W),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign ram_raddr  = (op_e'(operation_i) == OP_SCAN) ? cursor_q : {symbol_i, order_id_i};
  assign in_range   = (int'(sym_q) < SYMBOLS) && (int'(oid_q) < ORDERS_PER_SYMBOL);

  always_comb begin
    sel_kind = MSG_ACK;
    for (int i = MSG_N - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_kind = msg_e'(3'(i));
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cursor_d     = cursor_q;
    last_seq_d   = last_seq_q;
    snap_cnt_d   = snap_cnt_q;
    pend_d       = pend_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_seqerr_d = res_seqerr_q;
    ram_we       = 1'b0;
    ram_waddr    = addr_q;
    ram_wdata    = ram_rdata;
    out_load     = 1'b0;
    o_kind_d     = o_kind_q;
    o_idx_d      = o_idx_q;
    o_sym_d      = o_sym_q;
    o_ref_d      = o_ref_q;
    o_side_d     = o_side_q;
    o_price_d    = o_price_q;
    o_qty_d      = o_qty_q;
    o_prio_d     = o_prio_q;
    o_status_d   = o_status_q;
    o_seqerr_d   = o_seqerr_q;
    o_last_d     = o_last_q;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        pend_d = '0;
        if (op_q == OP_UPDATE) begin
          pend_d[MSG_ACK] = 1'b1;
          res_status_d    = STAT_OK;
          res_seqerr_d    = 1'b0;
          if (cursor_q != '0) begin
            res_status_d = STAT_BUSY;
          end else begin
            res_seqerr_d = (seq_q != last_seq_q + 1'b1);
            last_seq_d   = seq_q;
            if (kind_q != UPD_OTHER) begin
              if (!in_range) begin
                res_status_d = STAT_MISSING;
              end else if (kind_q == UPD_ADD) begin
                if (ram_rdata.valid) begin
                  res_status_d = STAT_DUP;
                end else begin
                  ram_we          = 1'b1;
                  ram_wdata.valid = 1'b1;
                  ram_wdata.side  = side_q;
                  ram_wdata.price = price_q;
                  ram_wdata.qty   = qty_q;
                  ram_wdata.prio  = prio_q;
                end
              end else if (!ram_rdata.valid) begin
                res_status_d = STAT_MISSING;
              end else if (ram_rdata.side != side_q) begin
                res_status_d = STAT_SIDE;
              end else if (kind_q == UPD_MODIFY) begin
                ram_we          = 1'b1;
                ram_wdata.price = price_q;
                ram_wdata.qty   = qty_q;
              end else begin
                ram_we          = 1'b1;
                ram_wdata.valid = 1'b0;
              end
            end
          end
        end else begin
          slot_d            = ram_rdata;
          pend_d[MSG_START] = (addr_q == '0);
          pend_d[MSG_CLEAR] = (addr_q[OID_W-1:0] == '0);
          pend_d[MSG_ORDER] = ram_rdata.valid;
          pend_d[MSG_END]   = (addr_q == ADDR_W'(SLOTS - 1));
          cursor_d          = (addr_q == ADDR_W'(SLOTS - 1)) ? '0 : addr_q + 1'b1;
        end
        state_d = (pend_d == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load   = 1'b1;
          pend_d     = pend_q & ~(MSG_N'(1) << sel_kind);
          o_kind_d   = sel_kind;
          o_idx_d    = snap_cnt_q;
          o_sym_d    = addr_q[ADDR_W-1:OID_W];
          o_ref_d    = '0;
          o_side_d   = '0;
          o_price_d  = '0;
          o_qty_d    = '0;
          o_prio_d   = '0;
          o_status_d = STAT_OK;
          o_seqerr_d = 1'b0;
          o_last_d   = (pend_d == '0);
          snap_cnt_d = snap_cnt_q + 1'b1;
          case (sel_kind)
            MSG_ACK: begin
              o_idx_d    = '0;
              o_sym_d    = sym_q;
              o_ref_d    = DATA_W'(oid_q);
              o_side_d   = side_q;
              o_price_d  = price_q;
              o_qty_d    = qty_q;
              o_prio_d   = prio_q;
              o_status_d = res_status_q;
              o_seqerr_d = res_seqerr_q;
              snap_cnt_d = snap_cnt_q;
            end
            MSG_START: begin
              o_idx_d    = '0;
              o_sym_d    = '0;
              o_ref_d    = last_seq_q;
              snap_cnt_d = IDX_W'(1);
            end
            MSG_CLEAR: begin
            end
            MSG_ORDER: begin
              o_ref_d   = DATA_W'(addr_q[OID_W-1:0]);
              o_side_d  = slot_q.side;
              o_price_d = slot_q.price;
              o_qty_d   = slot_q.qty;
              o_prio_d  = slot_q.prio;
            end
            MSG_END: begin
              o_sym_d = '0;
              o_ref_d = last_seq_q;
            end
            default: begin
            end
          endcase
          if (pend_d == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      last_seq_q  <= '0;
      snap_cnt_q  <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      last_seq_q  <= last_seq_d;
      snap_cnt_q  <= snap_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_e'(operation_i);
      kind_q  <= upd_e'(update_type_i);
      seq_q   <= seq_num_i;
      sym_q   <= symbol_i;
      oid_q   <= order_id_i;
      side_q  <= side_i;
      price_q <= price_i;
      qty_q   <= quantity_i;
      prio_q  <= priority_req_i;
      addr_q  <= ram_raddr;
    end
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_seqerr_q <= res_seqerr_d;
    o_kind_q     <= o_kind_d;
    o_idx_q      <= o_idx_d;
    o_sym_q      <= o_sym_d;
    o_ref_q      <= o_ref_d;
    o_side_q     <= o_side_d;
    o_price_q    <= o_price_d;
    o_qty_q      <= o_qty_d;
    o_prio_q     <= o_prio_d;
    o_status_q   <= o_status_d;
    o_seqerr_q   <= o_seqerr_d;
    o_last_q     <= o_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign msg_kind_o     = o_kind_q;
  assign snap_index_o   = o_idx_q;
  assign out_symbol_o   = o_sym_q;
  assign ref_value_o    = o_ref_q;
  assign out_side_o     = o_side_q;
  assign out_price_o    = o_price_q;
  assign out_quantity_o = o_qty_q;
  assign out_priority_o = o_prio_q;
  assign status_o       = o_status_q;
  assign seq_error_o    = o_seqerr_q;
  assign last_o         = o_last_q;

endmodule

// ===== design/obst_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the order book snapshot table, bound to the top level.
// Depends on obst_pkg and order_book_snapshot_table.
module obst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [2:0]                    msg_kind_o,
  input logic [obst_pkg::IDX_W-1:0]    snap_index_o,
  input logic [obst_pkg::DATA_W-1:0]   ref_value_o,
  input logic [2:0]                    status_o,
  input logic                          seq_error_o,
  input logic                          last_o
);
  import obst_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(msg_kind_o)
      && $stable(snap_index_o) && $stable(ref_value_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && msg_kind_o == MSG_ACK |-> last_o)
    else $error("update ack not marked last");

  a_start_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && msg_kind_o == MSG_START |-> snap_index_o == '0)
    else $error("snapshot start with nonzero index");

  a_seqerr_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seq_error_o |-> msg_kind_o == MSG_ACK && status_o != STAT_BUSY)
    else $error("sequence error on scan message or busy ack");

  a_scan_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && msg_kind_o != MSG_ACK |-> status_o == STAT_OK)
    else $error("scan message with error status");

endmodule

bind order_book_snapshot_table obst_checker u_obst_checker (.*);

// ===== tb/tb_order_book_snapshot_table.sv =====
`timescale 1ns / 1ps
// Self-checking bench for order_book_snapshot_table: drives update and scan transactions
// with random gaps and stalls, mirrors the order table in a scoreboard class.
// Depends on obst_pkg and the order_book_snapshot_table RTL.
module tb_order_book_snapshot_table;
  import obst_pkg::*;

  localparam int          HOT_N       = 12;
  localparam int          HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct {
    op_e                op;
    upd_e               kind;
    logic [SEQ_W-1:0]   seq;
    logic [SYM_W-1:0]   sym;
    logic [OID_W-1:0]   oid;
    logic [SIDE_W-1:0]  side;
    logic signed [DATA_W-1:0] price;
    logic [DATA_W-1:0]  qty;
    logic [DATA_W-1:0]  prio;
  } book_txn_t;

  typedef struct {
    msg_e               kind;
    logic [IDX_W-1:0]   idx;
    logic [SYM_W-1:0]   sym;
    logic [DATA_W-1:0]  refv;
    logic [SIDE_W-1:0]  side;
    logic [DATA_W-1:0]  price;
    logic [DATA_W-1:0]  qty;
    logic [DATA_W-1:0]  prio;
    status_e            status;
    logic               seq_err;
    logic               last;
  } book_msg_t;

  class book_scoreboard;
    bit                live[SLOTS];
    logic [SIDE_W-1:0] side_tab[SLOTS];
    logic [DATA_W-1:0] price_tab[SLOTS];
    logic [DATA_W-1:0] qty_tab[SLOTS];
    logic [DATA_W-1:0] prio_tab[SLOTS];
    logic [SEQ_W-1:0]  seq_last;
    logic [ADDR_W-1:0] scan_pos;
    logic [IDX_W-1:0]  msg_seq;
    book_msg_t         due_msgs[$];
    int                errors;
    int                checked;
    int                snapshots;

    function new();
      seq_last  = '0;
      scan_pos  = '0;
      msg_seq   = '0;
      errors    = 0;
      checked   = 0;
      snapshots = 0;
    endfunction

    function void push_msg(msg_e kind, logic [IDX_W-1:0] idx, logic [SYM_W-1:0] sym,
                           logic [DATA_W-1:0] refv, logic [SIDE_W-1:0] side,
                           logic [DATA_W-1:0] price, logic [DATA_W-1:0] qty,
                           logic [DATA_W-1:0] prio, status_e st, logic seq_err);
      book_msg_t m;
      m.kind    = kind;
      m.idx     = idx;
      m.sym     = sym;
      m.refv    = refv;
      m.side    = side;
      m.price   = price;
      m.qty     = qty;
      m.prio    = prio;
      m.status  = st;
      m.seq_err = seq_err;
      m.last    = 1'b0;
      due_msgs.push_back(m);
    endfunction

    function logic [IDX_W-1:0] next_idx();
      logic [IDX_W-1:0] v;
      v       = msg_seq;
      msg_seq = msg_seq + 1'b1;
      return v;
    endfunction

    // Works out the results of one accepted transaction and queues them.
    function void mirror_accepted(book_txn_t t);
      logic [ADDR_W-1:0] a;
      int                n_prior;
      status_e           st;
      logic              se;
      n_prior = due_msgs.size();
      if (t.op == OP_UPDATE) begin
        a  = {t.sym, t.oid};
        st = STAT_OK;
        if (scan_pos != '0) begin
          push_msg(MSG_ACK, '0, t.sym, {{(DATA_W-OID_W){1'b0}}, t.oid}, t.side, t.price,
                   t.qty, t.prio, STAT_BUSY, 1'b0);
        end else begin
          if (t.kind == UPD_ADD) begin
            if (live[a]) begin
              st = STAT_DUP;
            end else begin
              live[a]      = 1'b1;
              side_tab[a]  = t.side;
              price_tab[a] = t.price;
              qty_tab[a]   = t.qty;
              prio_tab[a]  = t.prio;
            end
          end else if (t.kind != UPD_OTHER) begin
            if (!live[a]) begin
              st = STAT_MISSING;
            end else if (side_tab[a] != t.side) begin
              st = STAT_SIDE;
            end else if (t.kind == UPD_MODIFY) begin
              price_tab[a] = t.price;
              qty_tab[a]   = t.qty;
            end else begin
              live[a] = 1'b0;
            end
          end
          se       = (t.seq != seq_last + 32'd1);
          seq_last = t.seq;
          push_msg(MSG_ACK, '0, t.sym, {{(DATA_W-OID_W){1'b0}}, t.oid}, t.side, t.price,
                   t.qty, t.prio, st, se);
        end
      end else begin
        a = scan_pos;
        if (a == '0) begin
          msg_seq = '0;
          push_msg(MSG_START, next_idx(), '0, seq_last, '0, '0, '0, '0, STAT_OK, 1'b0);
        end
        if (a[OID_W-1:0] == '0)
          push_msg(MSG_CLEAR, next_idx(), a[ADDR_W-1:OID_W], '0, '0, '0, '0, '0, STAT_OK, 1'b0);
        if (live[a])
          push_msg(MSG_ORDER, next_idx(), a[ADDR_W-1:OID_W],
                   {{(DATA_W-OID_W){1'b0}}, a[OID_W-1:0]}, side_tab[a], price_tab[a],
                   qty_tab[a], prio_tab[a], STAT_OK, 1'b0);
        if (&a) begin
          push_msg(MSG_END, next_idx(), '0, seq_last, '0, '0, '0, '0, STAT_OK, 1'b0);
          scan_pos = '0;
          snapshots++;
        end else begin
          scan_pos = a + 1'b1;
        end
      end
      if (due_msgs.size() > n_prior) due_msgs[due_msgs.size()-1].last = 1'b1;
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 1'b1;
      if (errors < 40)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1'b0;
    endfunction

    function void check_message(book_msg_t got);
      book_msg_t want;
      bit        bad;
      if (due_msgs.size() == 0) begin
        if (errors < 40)
          $display("%0t: result with none expected, expected nothing, actual kind %0d ref %h",
                   $time, got.kind, got.refv);
        errors++;
        return;
      end
      want = due_msgs.pop_front();
      checked++;
      bad = 1'b0;
      if (!field_ok("msg_kind", 32'(want.kind), 32'(got.kind)))       bad = 1'b1;
      if (!field_ok("snap_index", 32'(want.idx), 32'(got.idx)))       bad = 1'b1;
      if (!field_ok("out_symbol", 32'(want.sym), 32'(got.sym)))       bad = 1'b1;
      if (!field_ok("ref_value", want.refv, got.refv))                bad = 1'b1;
      if (!field_ok("out_side", 32'(want.side), 32'(got.side)))       bad = 1'b1;
      if (!field_ok("out_price", want.price, got.price))              bad = 1'b1;
      if (!field_ok("out_quantity", want.qty, got.qty))               bad = 1'b1;
      if (!field_ok("out_priority", want.prio, got.prio))             bad = 1'b1;
      if (!field_ok("status", 32'(want.status), 32'(got.status)))     bad = 1'b1;
      if (!field_ok("seq_error", 32'(want.seq_err), 32'(got.seq_err))) bad = 1'b1;
      if (!field_ok("last", 32'(want.last), 32'(got.last)))           bad = 1'b1;
      if (bad) errors++;
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     operation_i;
  logic [1:0]               update_type_i;
  logic [SEQ_W-1:0]         seq_num_i;
  logic [SYM_W-1:0]         symbol_i;
  logic [OID_W-1:0]         order_id_i;
  logic [SIDE_W-1:0]        side_i;
  logic signed [DATA_W-1:0] price_i;
  logic [DATA_W-1:0]        quantity_i;
  logic [DATA_W-1:0]        priority_req_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [2:0]               msg_kind_o;
  logic [IDX_W-1:0]         snap_index_o;
  logic [SYM_W-1:0]         out_symbol_o;
  logic [DATA_W-1:0]        ref_value_o;
  logic [SIDE_W-1:0]        out_side_o;
  logic signed [DATA_W-1:0] out_price_o;
  logic [DATA_W-1:0]        out_quantity_o;
  logic [DATA_W-1:0]        out_priority_o;
  logic [2:0]               status_o;
  logic                     seq_error_o;
  logic                     last_o;

  book_scoreboard    sb;
  book_msg_t         seen_msg;
  logic [ADDR_W-1:0] hot_slots[HOT_N];
  bit                hold_request;
  int                burst_left;
  int                n_updates;
  int                n_scan_steps;
  int unsigned       cycle_count;

  order_book_snapshot_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .update_type_i  (update_type_i),
    .seq_num_i      (seq_num_i),
    .symbol_i       (symbol_i),
    .order_id_i     (order_id_i),
    .side_i         (side_i),
    .price_i        (price_i),
    .quantity_i     (quantity_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .msg_kind_o     (msg_kind_o),
    .snap_index_o   (snap_index_o),
    .out_symbol_o   (out_symbol_o),
    .ref_value_o    (ref_value_o),
    .out_side_o     (out_side_o),
    .out_price_o    (out_price_o),
    .out_quantity_o (out_quantity_o),
    .out_priority_o (out_priority_o),
    .status_o       (status_o),
    .seq_error_o    (seq_error_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic book_txn_t update_item(upd_e kind, logic [SEQ_W-1:0] seq,
                                            logic [SYM_W-1:0] sym, logic [OID_W-1:0] oid,
                                            logic [SIDE_W-1:0] side, logic [DATA_W-1:0] price,
                                            logic [DATA_W-1:0] qty, logic [DATA_W-1:0] prio);
    book_txn_t t;
    t.op    = OP_UPDATE;
    t.kind  = kind;
    t.seq   = seq;
    t.sym   = sym;
    t.oid   = oid;
    t.side  = side;
    t.price = price;
    t.qty   = qty;
    t.prio  = prio;
    return t;
  endfunction

  // Mostly in-sequence traffic on a few hot slots with matching sides; some noise.
  function automatic book_txn_t random_update();
    book_txn_t         t;
    logic [ADDR_W-1:0] a;
    int                r;
    r      = $urandom_range(99);
    t.op   = OP_UPDATE;
    t.kind = (r < 35) ? UPD_ADD : (r < 65) ? UPD_MODIFY : (r < 90) ? UPD_CANCEL : UPD_OTHER;
    if ($urandom_range(9) == 0) a = ADDR_W'($urandom);
    else a = hot_slots[$urandom_range(HOT_N - 1)];
    t.sym  = a[ADDR_W-1:OID_W];
    t.oid  = a[OID_W-1:0];
    if ($urandom_range(19) == 0) t.side = SIDE_W'($urandom);
    else t.side = ($urandom_range(1) == 0) ? 2'd1 : 2'd2;
    if (t.kind != UPD_ADD && sb.live[a] && $urandom_range(7) != 0) t.side = sb.side_tab[a];
    if ($urandom_range(9) == 0) t.seq = $urandom;
    else t.seq = sb.seq_last + 32'd1;
    r = $urandom_range(9);
    if (r == 0) t.price = 32'h8000_0000;
    else if (r == 1) t.price = 32'h7FFF_FFFF;
    else t.price = $urandom;
    t.qty  = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
    t.prio = $urandom;
    return t;
  endfunction

  function automatic int sender_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input book_txn_t t);
    int gap;
    in_valid_i     <= 1'b1;
    operation_i    <= t.op;
    update_type_i  <= t.kind;
    seq_num_i      <= t.seq;
    symbol_i       <= t.sym;
    order_id_i     <= t.oid;
    side_i         <= t.side;
    price_i        <= t.price;
    quantity_i     <= t.qty;
    priority_req_i <= t.prio;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.mirror_accepted(t);
    if (t.op == OP_UPDATE) n_updates++;
    else n_scan_steps++;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Steps the scan n slots, with an occasional update that bounces busy while a scan is under way.
  task automatic scan_steps(input int n);
    book_txn_t t;
    repeat (n) begin
      if ($urandom_range(4) == 0) send_item(random_update());
      t    = random_update();
      t.op = OP_SCAN;
      send_item(t);
    end
  endtask

  initial begin : result_sink
    int r;
    int span;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(99);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        span = HOLD_CYCLES;
      end else if (r < 45) begin
        out_ready_i <= 1'b1;
        span = $urandom_range(1, 8);
      end else if (r < 60) begin
        out_ready_i <= 1'b1;
        span = $urandom_range(20, 60);
      end else if (r < 92) begin
        out_ready_i <= 1'b0;
        span = $urandom_range(1, 3);
      end else begin
        out_ready_i <= 1'b0;
        span = $urandom_range(10, 40);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      seen_msg.kind    = msg_e'(msg_kind_o);
      seen_msg.idx     = snap_index_o;
      seen_msg.sym     = out_symbol_o;
      seen_msg.refv    = ref_value_o;
      seen_msg.side    = out_side_o;
      seen_msg.price   = out_price_o;
      seen_msg.qty     = out_quantity_o;
      seen_msg.prio    = out_priority_o;
      seen_msg.status  = status_e'(status_o);
      seen_msg.seq_err = seq_error_o;
      seen_msg.last    = last_o;
      sb.check_message(seen_msg);
    end
  end

  initial begin : stimulus
    book_txn_t t;
    sb           = new();
    hold_request = 1'b0;
    burst_left   = 0;
    n_updates    = 0;
    n_scan_steps = 0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    operation_i    <= OP_UPDATE;
    update_type_i  <= UPD_ADD;
    seq_num_i      <= '0;
    symbol_i       <= '0;
    order_id_i     <= '0;
    side_i         <= '0;
    price_i        <= '0;
    quantity_i     <= '0;
    priority_req_i <= '0;
    hot_slots[0] = '0;
    hot_slots[1] = '1;
    hot_slots[2] = {3'd3, 10'd0};
    for (int i = 3; i < HOT_N; i++) hot_slots[i] = ADDR_W'($urandom);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every status but busy, sequence wrap
    send_item(update_item(UPD_ADD, sb.seq_last + 32'd1, 3'd0, 10'd0, 2'd1,
                          32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    send_item(update_item(UPD_ADD, sb.seq_last + 32'd1, 3'd7, 10'd1023, 2'd2,
                          32'h8000_0000, 32'h0, 32'hFFFF_FFFF));
    send_item(update_item(UPD_ADD, sb.seq_last + 32'd1, 3'd0, 10'd0, 2'd1, 32'd5, 32'd6,
                          32'd7));
    send_item(update_item(UPD_MODIFY, sb.seq_last + 32'd1, 3'd0, 10'd0, 2'd1,
                          32'hFFFF_FFFF, 32'd5, 32'd9));
    send_item(update_item(UPD_MODIFY, sb.seq_last + 32'd1, 3'd0, 10'd0, 2'd2, 32'd1, 32'd1,
                          32'd1));
    send_item(update_item(UPD_CANCEL, sb.seq_last + 32'd1, 3'd5, 10'd17, 2'd1, 32'd0, 32'd0,
                          32'd0));
    send_item(update_item(UPD_MODIFY, sb.seq_last + 32'd1, 3'd5, 10'd18, 2'd2, 32'd3, 32'd4,
                          32'd0));
    send_item(update_item(UPD_OTHER, sb.seq_last + 32'd2, 3'd2, 10'd99, 2'd0, 32'd0, 32'd0,
                          32'd0));
    send_item(update_item(UPD_ADD, sb.seq_last + 32'd1, 3'd3, 10'd0, 2'd3, $urandom, $urandom,
                          $urandom));
    send_item(update_item(UPD_ADD, 32'hFFFF_FFFF, 3'd4, 10'd512, 2'd0, $urandom, $urandom,
                          $urandom));
    send_item(update_item(UPD_ADD, sb.seq_last + 32'd1, 3'd4, 10'd513, 2'd2, 32'd10, 32'd20,
                          32'd30));
    send_item(update_item(UPD_CANCEL, sb.seq_last + 32'd1, 3'd4, 10'd513, 2'd2, 32'd0,
                          32'd0, 32'd0));
    send_item(update_item(UPD_CANCEL, sb.seq_last, 3'd4, 10'd513, 2'd2, 32'd0, 32'd0, 32'd0));
    send_item(update_item(UPD_MODIFY, sb.seq_last + 32'd1, 3'd3, 10'd0, 2'd3, 32'h8000_0000,
                          32'hFFFF_FFFF, 32'd0));
    send_item(update_item(UPD_ADD, sb.seq_last + 32'd1, 3'd6, 10'd341, 2'd1, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'h5555_5555));
    send_item(update_item(UPD_ADD, sb.seq_last + 32'd1, 3'd1, 10'd682, 2'd2, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hAAAA_AAAA));
    send_item(update_item(UPD_ADD, sb.seq_last + 32'd1, 3'd2, 10'd5, 2'd1, 32'd1, 32'd2,
                          32'd3));
    send_item(update_item(UPD_OTHER, $urandom, 3'd7, 10'd7, 2'd2, 32'd0, 32'd0, 32'd0));

    // random updates; the sink holds off at the start so the input backs up
    hold_request = 1'b1;
    repeat (60) send_item(random_update());
    repeat (45) send_item(random_update());

    // slots near the start of the table, so the scan has orders to report
    if (!sb.live[0])
      send_item(update_item(UPD_ADD, sb.seq_last + 32'd1, 3'd0, 10'd0, 2'd1, $urandom,
                            $urandom, $urandom));
    if (!sb.live[3])
      send_item(update_item(UPD_ADD, sb.seq_last + 32'd1, 3'd0, 10'd3, 2'd2, $urandom,
                            $urandom, $urandom));
    scan_steps(25);
    in_valid_i <= 1'b0;

    while (sb.due_msgs.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Run covered %0d updates and %0d scan steps, %0d full snapshots.",
             n_updates, n_scan_steps, sb.snapshots);
    $display("%0d results compared, %0d with mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
